[rtl/lirs_pkg.sv]
// Shared types and constants of the linear interpolating resampler.
package lirs_pkg;

   // The emission run stops after this many results for one input item.
   localparam int MAX_RESULTS = 64;
   localparam int COUNT_BITS  = $clog2(MAX_RESULTS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_pass;    // bypass: load the output with the input sample
      logic skip;         // phase at or above one: drop one from the phase
      logic start;        // begin a run: latch the base sample and difference
      logic mul;          // multiply the difference by the phase fraction, step the phase
      logic add;          // form the output sample from the product
      logic finish;       // end of run: take one off the phase or clear it
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic step_zero;    // output disabled
      logic step_one;     // bypass step
      logic phase_ge_one; // current phase is at or above one
      logic next_ge_one;  // phase plus step reaches one
   } status_type;

endpackage

[rtl/lirs_datapath.sv]
// Datapath of the resampler: step register, phase, sample history and interpolator.
module lirs_datapath
   import lirs_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [FRAC_BITS+7:0]          csr_wr_data,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  cmd_type                       cmd,
   output status_type                    status,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   localparam int SB = SAMPLE_BITS;
   localparam int FB = FRAC_BITS;
   localparam logic [FB+8:0] PHASE_ONE = (FB+9)'(1) << FB;
   localparam logic [FB+7:0] STEP_ONE  = (FB+8)'(1) << FB;
   localparam logic [FB+7:0] MIN_STEP  = (FB+8)'(1) << (FB-6);

   logic [FB+7:0]          step_ff;
   logic [FB+8:0]          phase_ff, phase_in;
   logic signed [SB-1:0]   prev_ff;
   logic                   have_prev_ff;
   logic signed [SB-1:0]   base_ff, base_in;
   logic signed [SB:0]     diff_ff, diff_in;
   logic signed [SB+FB+1:0] prod_ff, prod_in;
   logic signed [SB-1:0]   out_ff, out_in;

   logic [FB+7:0]          step_eff;
   logic [FB+8:0]          phase_sum;
   logic signed [FB:0]     frac_s;
   logic signed [SB+FB+1:0] prod_shift;

   // Very small nonzero steps are raised so one input yields a bounded run.
   assign step_eff  = (step_ff < MIN_STEP) ? MIN_STEP : step_ff;
   assign phase_sum = phase_ff + {1'b0, step_eff};

   assign status.step_zero    = (step_ff == '0);
   assign status.step_one     = (step_ff == STEP_ONE);
   assign status.phase_ge_one = (phase_ff >= PHASE_ONE);
   assign status.next_ge_one  = (phase_sum >= PHASE_ONE);

   // The first sample stands in as its own predecessor.
   assign base_in = have_prev_ff ? prev_ff : sample;
   assign diff_in = {sample[SB-1], sample} - {base_in[SB-1], base_in};

   assign frac_s     = $signed({1'b0, phase_ff[FB-1:0]});
   assign prod_in    = diff_ff * frac_s;
   assign prod_shift = prod_ff >>> FB;
   assign out_in     = base_ff + prod_shift[SB-1:0];

   always_comb begin
      phase_in = phase_ff;
      if (cmd.skip) begin
         phase_in = phase_ff - PHASE_ONE;
      end else if (cmd.mul) begin
         phase_in = phase_sum;
      end else if (cmd.finish) begin
         phase_in = status.phase_ge_one ? (phase_ff - PHASE_ONE) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         phase_ff     <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         if (cmd.load_pass || cmd.skip || cmd.start) begin
            prev_ff      <= sample;
            have_prev_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         base_ff <= base_in;
         diff_ff <= diff_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_pass) begin
         out_ff <= sample;
      end else if (cmd.add) begin
         out_ff <= out_in;
      end
   end

   assign out_sample = out_ff;

endmodule

[rtl/lirs_ctrl.sv]
// Controller state machine of the resampler: handshakes, run sequencing and result count.
module lirs_ctrl
   import lirs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic       rsp_tlast,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_RESULTS - 1);

   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  last_ff, last_in;
   logic                  req_fire, rsp_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tlast  = last_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      last_in  = last_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && !status.step_zero) begin
               if (status.step_one) begin
                  cmd.load_pass = 1'b1;
                  last_in       = 1'b1;
                  state_in      = ST_EMIT;
               end else if (status.phase_ge_one) begin
                  cmd.skip = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  count_in  = '0;
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            last_in  = status.next_ge_one || (count_ff == COUNT_MAX);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add    = 1'b1;
            cmd.finish = last_ff;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

`ifndef SYNTHESIS
   // Inputs are never taken while a result is on offer.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   // The add step always follows a multiply step.
   a_add_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> ($past(state_ff) == ST_MUL))
      else $error("add step without a preceding multiply");

   // Delivering the last result of a run frees the input side.
   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && last_ff) |=> req_tready)
      else $error("input side not ready after the last result");

   // A full run ends on its final result.
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && count_ff == COUNT_MAX) |-> last_ff)
      else $error("run exceeded the result limit");
`endif

endmodule

[rtl/linear_interpolating_resampler.sv]
// Top level of the linear interpolating resampler: controller plus datapath.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_tvalid/req_tready   req_tdata: sample
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata: out_sample, rsp_tlast: run_last
//   csr      in         csr_wr_en               csr_wr_data: phase_step
//
// A bypass step offers its result in the next cycle. An interpolated run takes each
// result through a multiply, an add and the output register, paced by the single
// shared multiplier and its registered adder. The block works on one item at a time.
// Reset is synchronous and active high and clears step, phase and sample history.
// A stalled result holds in the output register until it is taken.
module linear_interpolating_resampler
   import lirs_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input item channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,  // sample, then zero fill
   // Result item channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,  // out_sample, then zero fill
   output logic                                 rsp_tlast,  // run_last
   // Step register write port.
   input  logic                                 csr_wr_en,
   input  logic [FRAC_BITS+7:0]                 csr_wr_data  // phase_step, unsigned 8.FRAC
);

   localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   cmd_type                       cmd;
   status_type                    status;
   logic signed [SAMPLE_BITS-1:0] out_sample;

   // The controller sequences each item: accept, then per result a multiply,
   // an add into the output register and the output handshake.
   lirs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the step, the phase, the previous sample and the
   // interpolator, whose result waits in an output register.
   lirs_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .sample      ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .cmd         (cmd),
      .status      (status),
      .out_sample  (out_sample)
   );

   // Unused upper bits of the data bus are driven to zero.
   assign rsp_tdata = DATA_BITS'($unsigned(out_sample));

endmodule

[test/tb_linear_interpolating_resampler.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the linear interpolating resampler.
module tb_linear_interpolating_resampler;
   import lirs_pkg::MAX_RESULTS;

   localparam int          SAMPLE_W       = 16;
   localparam int          FRAC_W         = 16;
   // Step settings with a special meaning, unsigned 8.16.
   localparam logic [23:0] STEP_OFF       = 24'h000000;
   localparam logic [23:0] STEP_UNITY     = 24'h010000;
   localparam logic [23:0] STEP_FLOOR     = 24'h000400;
   localparam logic [23:0] STEP_MAX       = 24'hFFFFFF;
   localparam logic [24:0] PHASE_ONE      = 25'h0010000;
   // Cycles to let the block finish an item that yields no output before a step write.
   localparam int          SETTLE_CYCLES  = 8;
   // Cycles without any handshake before the run is declared hung.
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          HOLD_CYCLES    = 200;

   typedef struct packed {
      logic [SAMPLE_W-1:0] out_sample;
      logic                run_last;
   } resampled_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata   = '0;   // sample
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;          // out_sample
   logic                rsp_tlast;          // run_last
   logic                csr_wr_en   = 1'b0;
   logic [FRAC_W+7:0]   csr_wr_data = '0;   // phase_step

   // Predictor state: a private copy of what the block keeps between items.
   logic [23:0]                step_reg     = STEP_OFF;
   logic [24:0]                phase_acc    = '0;
   logic signed [SAMPLE_W-1:0] last_sample  = '0;
   logic                       have_last    = 1'b0;

   // Output samples predicted but not yet seen on the output, oldest first.
   resampled_type pending_outputs[$];

   int  mismatch_count  = 0;
   int  items_sent      = 0;
   int  outputs_checked = 0;
   int  steps_written   = 0;
   int  quiet_cycles    = 0;
   int  hold_requests   = 0;
   bit  gaps_on         = 1'b1;

   linear_interpolating_resampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Works out the output samples that one accepted input sample causes and queues
   // them. A zero step yields nothing, a unity step passes the sample through, and
   // otherwise the phase walks across the new interval in steps of at least 1/64.
   function automatic void predict_outputs(input logic signed [SAMPLE_W-1:0] cur);
      logic [23:0]                eff_step;
      logic signed [SAMPLE_W-1:0] base;
      longint                     product;
      longint                     interp;
      int                         count;
      resampled_type              r;
      if (step_reg == STEP_OFF) return;
      if (step_reg == STEP_UNITY) begin
         r.out_sample = cur;
         r.run_last   = 1'b1;
         pending_outputs.insert(pending_outputs.size(), r);
         last_sample = cur;
         have_last   = 1'b1;
         return;
      end
      eff_step = (step_reg < STEP_FLOOR) ? STEP_FLOOR : step_reg;
      // Right after reset the first sample is its own predecessor.
      base  = have_last ? last_sample : cur;
      count = 0;
      while (phase_acc < PHASE_ONE && count < MAX_RESULTS) begin
         product      = (longint'(cur) - longint'(base)) * longint'(phase_acc);
         // The arithmetic shift of a signed value rounds toward minus infinity.
         interp       = longint'(base) + (product >>> FRAC_W);
         r.out_sample = interp[SAMPLE_W-1:0];
         r.run_last   = (phase_acc + eff_step >= PHASE_ONE) || (count == MAX_RESULTS - 1);
         pending_outputs.insert(pending_outputs.size(), r);
         count++;
         phase_acc = phase_acc + eff_step;
      end
      // A phase that was already at or above one only loses one whole sample.
      if (phase_acc >= PHASE_ONE) phase_acc = phase_acc - PHASE_ONE;
      else phase_acc = '0;
      last_sample = cur;
      have_last   = 1'b1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 11))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // Mostly rates near the usual audio ratios, sometimes the special steps.
   function automatic logic [23:0] rand_step();
      case ($urandom_range(0, 11))
         0:       return STEP_UNITY;
         1:       return STEP_OFF;
         2:       return 24'($urandom_range(1, STEP_FLOOR - 1));
         3:       return 24'($urandom_range(24'h010001, 24'h040000));
         4:       return 24'($urandom_range(24'h00F000, 24'h011000));
         default: return 24'($urandom_range(STEP_FLOOR, 24'h020000));
      endcase
   endfunction

   // Offers one sample, with an occasional idle burst first, and returns at the
   // edge where it is taken. Valid stays high so the next item can follow at once.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predict_outputs(value);
      items_sent++;
   endtask

   // Waits until every predicted output has come back, then lets the block settle
   // in case the last item yielded nothing and is still being worked on.
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The step register is only written while the block is idle.
   task automatic write_phase_step(input logic [23:0] value);
      drain_outputs();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      step_reg = value;
      csr_wr_en <= 1'b0;
      steps_written++;
   endtask

   // A zero step disables output and leaves the state untouched, so the sample
   // history is still empty for the next test.
   task automatic test_step_off();
      write_phase_step(STEP_OFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
   endtask

   // Half-rate step: the first sample after reset stands in as its own predecessor,
   // then full-scale swings check the widest differences.
   task automatic test_first_sample_upsample();
      write_phase_step(24'h008000);
      send_sample(16'h1234);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
   endtask

   // Tiny steps are raised to the floor, giving the longest runs of 64 outputs.
   task automatic test_step_floor();
      write_phase_step(24'h000001);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      write_phase_step(STEP_FLOOR - 1);
      send_sample(16'h0001);
   endtask

   // Downsampling leaves the phase at or above one for some items, which are skipped.
   task automatic test_downsample_skip();
      write_phase_step(24'h028000);
      send_sample(16'h4000);
      send_sample(16'hC000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
   endtask

   // A unity step passes samples straight through, one output per item.
   task automatic test_bypass();
      write_phase_step(STEP_UNITY);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
   endtask

   // Steps one LSB off unity go through the interpolating path, not the bypass.
   task automatic test_near_unity();
      write_phase_step(STEP_UNITY - 1);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      write_phase_step(STEP_UNITY + 1);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
   endtask

   // The output side holds off for a long stretch while the sender keeps offering
   // items, so the block fills up and must stall its input.
   task automatic test_output_backpressure();
      write_phase_step(STEP_FLOOR);
      gaps_on = 1'b0;
      hold_requests++;
      repeat (8) send_sample(rand_sample());
      gaps_on = 1'b1;
   endtask

   // Random step settings, each followed by a batch of random samples.
   task automatic test_random_rates(input int batches, input bit with_gaps);
      gaps_on = with_gaps;
      repeat (batches) begin
         write_phase_step(rand_step());
         repeat ($urandom_range(20, 40)) send_sample(rand_sample());
      end
   endtask

   // The largest step is run last: it leaves the phase far above one, and every
   // later item would only be skipped.
   task automatic test_max_step();
      write_phase_step(STEP_MAX);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h1111);
   endtask

   // Output ready: random stall bursts, or a long counted hold-off on request.
   initial begin : drive_ready
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void report_mismatch(input string what, input resampled_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected sample %h last %b, got sample %h last %b",
                  $realtime, what, want.out_sample, want.run_last, rsp_tdata, rsp_tlast);
   endfunction

   // Every output taken is compared with the oldest prediction.
   always @(posedge clock) begin : check_outputs
      resampled_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         outputs_checked++;
         if (pending_outputs.size() == 0) begin
            want = '0;
            report_mismatch("output with nothing predicted", want);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_tdata !== want.out_sample || rsp_tlast !== want.run_last)
               report_mismatch("output mismatch", want);
         end
      end
   end

   // The run is declared hung when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d outputs still predicted",
                  WATCHDOG_LIMIT, pending_outputs.size());
         $display("tb_linear_interpolating_resampler: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_step_off();
      test_first_sample_upsample();
      test_step_floor();
      test_downsample_skip();
      test_bypass();
      test_near_unity();
      test_output_backpressure();
      test_random_rates(10, 1'b1);
      // The final stretch runs with both sides at full rate.
      test_random_rates(2, 1'b0);
      test_max_step();
      drain_outputs();
      $display("Sent %0d input items across %0d step settings, checked %0d outputs.",
               items_sent, steps_written, outputs_checked);
      $display("Mismatches: %0d, predictions left over: %0d.",
               mismatch_count, pending_outputs.size());
      if (mismatch_count == 0 && pending_outputs.size() == 0)
         $display("tb_linear_interpolating_resampler: PASS");
      else
         $display("tb_linear_interpolating_resampler: FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/lirs_pkg.sv
rtl/lirs_datapath.sv
rtl/lirs_ctrl.sv
rtl/linear_interpolating_resampler.sv
test/tb_linear_interpolating_resampler.sv
